### design/touch_sample_average_calibrate_core_defines.svh
// Assertion macros shared by the touch averaging and calibration RTL.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef TOUCH_SAMPLE_AVERAGE_CALIBRATE_CORE_DEFINES_SVH
`define TOUCH_SAMPLE_AVERAGE_CALIBRATE_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define TSAC_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define TSAC_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/tsac_pkg.sv
// Types, register codes and helpers for the touch averaging/calibration block.
// No dependencies; imported by the front end, back end and top module of the block.
`default_nettype none

package tsac_pkg;

  localparam int SAMPLE_W = 13;
  localparam int SUM_W    = 19;
  localparam int LANES    = 3;
  localparam int LANE_X   = 0;
  localparam int LANE_Y   = 1;
  localparam int LANE_Z   = 2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_MODE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_X_FACTOR      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_FACTOR      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_X_OFFSET      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_OFFSET      = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_Z_THRESHOLD   = 3'd7;

  // control_mode bit positions
  localparam int CM_EIGHT_BIT = 2;
  localparam int CM_PEN_IRQ   = 3;

  // orientation codes, control_mode[1:0]
  localparam logic [1:0] ORIENT_PORTRAIT       = 2'd0;
  localparam logic [1:0] ORIENT_PORTRAIT_FLIP  = 2'd1;
  localparam logic [1:0] ORIENT_LANDSCAPE      = 2'd2;
  localparam logic [1:0] ORIENT_LANDSCAPE_FLIP = 2'd3;

  typedef struct packed {
    logic [7:0] x_high;
    logic [7:0] x_low;
    logic [7:0] y_high;
    logic [7:0] y_low;
    logic [7:0] z1_high;
    logic [7:0] z1_low;
    logic       pen_down;
  } in_t;

  typedef struct packed {
    logic [15:0]         pos_x;
    logic [15:0]         pos_y;
    logic [SAMPLE_W-1:0] pressure;
    logic                pressed;
  } out_t;

  typedef struct packed {
    logic [3:0]          control_mode;
    logic [15:0]         screen_width;
    logic [15:0]         screen_height;
    logic [23:0]         x_factor;
    logic [23:0]         y_factor;
    logic [15:0]         x_offset;
    logic [15:0]         y_offset;
    logic [SAMPLE_W-1:0] z_threshold;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    control_mode:  4'd8,
    screen_width:  16'd240,
    screen_height: 16'd320,
    x_factor:      24'd0,
    y_factor:      24'd0,
    x_offset:      16'd0,
    y_offset:      16'd0,
    z_threshold:   13'd0
  };

  // One unit of work for the back end: a finished batch or a pen-up report.
  typedef struct packed {
    logic                        zero;
    logic                        pen;
    logic [LANES-1:0][SUM_W-1:0] sum;
  } job_t;

  function automatic logic [SAMPLE_W-1:0] sample(input logic [7:0] hi,
                                                 input logic [7:0] lo,
                                                 input logic       eight_bit);
    logic [SAMPLE_W-1:0] s;
    if (eight_bit) begin
      s = {5'd0, lo};
    end else begin
      s = {hi, lo[7:3]};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### design/tsac_queue.sv
// Small register-based FIFO used between front and back end and at the output.
// Depends on nothing; payload is a flat vector.
`default_nettype none

module tsac_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/tsac_front.sv
// Front end: takes converter rounds, extracts samples and accumulates a batch.
// Depends on tsac_pkg; emits one job per finished batch or pen-up round.
`default_nettype none
`include "touch_sample_average_calibrate_core_defines.svh"

module tsac_front
  import tsac_pkg::*;
#(
  parameter int ROUNDS_PER_BATCH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic push,
  input  wire in_t  in_data,
  output logic      full,
  output logic      job_push,
  output job_t      job,
  input  wire logic job_full
);

  localparam int CNT_W = (ROUNDS_PER_BATCH > 1) ? $clog2(ROUNDS_PER_BATCH) : 1;
  localparam logic [CNT_W-1:0] LAST_ROUND = CNT_W'(ROUNDS_PER_BATCH - 1);

  logic [LANES-1:0][SUM_W-1:0] sum;
  logic [LANES-1:0][SUM_W-1:0] sum_next;
  logic [CNT_W-1:0]            count;
  logic [LANES-1:0][SAMPLE_W-1:0] smp;
  logic accept;
  logic pen_up;
  logic batch_end;

  assign full   = job_full;
  assign accept = push && !job_full;

  always_comb begin
    smp[LANE_X] = sample(in_data.x_high,  in_data.x_low,  cfg.control_mode[CM_EIGHT_BIT]);
    smp[LANE_Y] = sample(in_data.y_high,  in_data.y_low,  cfg.control_mode[CM_EIGHT_BIT]);
    smp[LANE_Z] = sample(in_data.z1_high, in_data.z1_low, cfg.control_mode[CM_EIGHT_BIT]);
    for (int i = 0; i < LANES; i++) begin
      sum_next[i] = sum[i] + SUM_W'(smp[i]);
    end
  end

  // pen lifted before the first round of a batch: report at once, no accumulation
  assign pen_up    = cfg.control_mode[CM_PEN_IRQ] && (count == '0) && !in_data.pen_down;
  assign batch_end = !pen_up && (count == LAST_ROUND);
  assign job_push  = accept && (pen_up || batch_end);

  always_comb begin
    job.zero = pen_up;
    job.pen  = in_data.pen_down;
    job.sum  = pen_up ? '0 : sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (accept && !pen_up) begin
      if (batch_end) begin
        sum   <= '0;
        count <= '0;
      end else begin
        sum   <= sum_next;
        count <= count + 1'b1;
      end
    end
  end

  `TSAC_ASSERT_IMP(a_pen_up_at_start, clk, rst, job_push && job.zero, count == '0)
  `TSAC_ASSERT_NEXT(a_batch_restart, clk, rst, accept && batch_end, count == '0 && sum == '0)
  `TSAC_ASSERT_IMP(a_job_room, clk, rst, job_push, !job_full)

endmodule

`default_nettype wire

### design/tsac_back.sv
// Back end: averages batch sums and maps them to calibrated screen coordinates.
// Depends on tsac_pkg; three register stages, stalls as a whole on a full output.
`default_nettype none
`include "touch_sample_average_calibrate_core_defines.svh"

module tsac_back
  import tsac_pkg::*;
#(
  parameter int ROUNDS_PER_BATCH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      job_pop,
  output logic      res_push,
  output out_t      res,
  input  wire logic res_full
);

  localparam int RECIP_W = SUM_W + 1;
  localparam int DIVP_W  = SUM_W + RECIP_W;
  localparam int N_W     = $clog2(ROUNDS_PER_BATCH + 1);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SUM_W) / ROUNDS_PER_BATCH);
  localparam logic [N_W-1:0]     N_VAL = N_W'(ROUNDS_PER_BATCH);
  localparam int PROD_W = 24 + SAMPLE_W + 1;
  localparam int FLR_W  = PROD_W - 20;
  localparam int ACC_W  = 20;

  logic adv;

  // stage 1: quotient estimate by reciprocal
  logic                         s1_valid;
  logic                         s1_zero;
  logic                         s1_pen;
  logic [LANES-1:0][SUM_W-1:0]  s1_sum;
  logic [LANES-1:0][SUM_W-1:0]  s1_qe;
  logic [LANES-1:0][SUM_W-1:0]  qe_next;
  logic [DIVP_W-1:0]            divp;

  // stage 2: corrected averages
  logic                           s2_valid;
  logic                           s2_zero;
  logic                           s2_pen;
  logic [LANES-1:0][SAMPLE_W-1:0] s2_avg;
  logic [LANES-1:0][SAMPLE_W-1:0] avg_next;
  logic [LANES-1:0][SUM_W-1:0]    rem;
  logic [SUM_W-1:0]               qn;

  // stage 3: scaled products
  logic                     s3_valid;
  logic                     s3_zero;
  logic                     s3_pen;
  logic [SAMPLE_W-1:0]      s3_avg_z;
  logic signed [PROD_W-1:0] s3_p_x;
  logic signed [PROD_W-1:0] s3_p_y;
  logic signed [23:0]       fx;
  logic signed [23:0]       fy;
  logic [SAMPLE_W-1:0]      ax;
  logic [SAMPLE_W-1:0]      ay;
  logic signed [PROD_W-1:0] p_x_next;
  logic signed [PROD_W-1:0] p_y_next;

  // output mapping
  logic [1:0]               orient;
  logic                     neg_x;
  logic                     neg_y;
  logic signed [ACC_W-1:0]  base_x;
  logic signed [ACC_W-1:0]  base_y;
  logic signed [PROD_W-1:0] pn_x;
  logic signed [PROD_W-1:0] pn_y;
  logic signed [ACC_W-1:0]  c_x;
  logic signed [ACC_W-1:0]  c_y;
  logic [15:0]              sat_x;
  logic [15:0]              sat_y;
  logic                     press;
  logic signed [ACC_W-1:0]  w_ext;
  logic signed [ACC_W-1:0]  h_ext;
  logic signed [ACC_W-1:0]  xo_ext;
  logic signed [ACC_W-1:0]  yo_ext;

  assign adv      = !(s3_valid && res_full);
  assign job_pop  = adv && job_valid;
  assign res_push = s3_valid && !res_full;

  always_comb begin
    divp = '0;
    for (int i = 0; i < LANES; i++) begin
      divp       = DIVP_W'(job.sum[i]) * DIVP_W'(RECIP);
      qe_next[i] = divp[DIVP_W-2:SUM_W];
    end
  end

  // estimate is exact or one low
  always_comb begin
    qn = '0;
    for (int i = 0; i < LANES; i++) begin
      qn          = s1_qe[i] * SUM_W'(N_VAL);
      rem[i]      = s1_sum[i] - qn;
      avg_next[i] = SAMPLE_W'(s1_qe[i]) + SAMPLE_W'(rem[i] >= SUM_W'(N_VAL));
    end
  end

  assign orient = cfg.control_mode[1:0];

  always_comb begin
    unique case (orient)
      ORIENT_PORTRAIT: begin
        fx = $signed(cfg.y_factor); ax = s2_avg[LANE_Y];
        fy = $signed(cfg.x_factor); ay = s2_avg[LANE_X];
      end
      ORIENT_PORTRAIT_FLIP: begin
        fx = $signed(cfg.x_factor); ax = s2_avg[LANE_Y];
        fy = $signed(cfg.x_factor); ay = s2_avg[LANE_X];
      end
      ORIENT_LANDSCAPE: begin
        fx = $signed(cfg.x_factor); ax = s2_avg[LANE_X];
        fy = $signed(cfg.y_factor); ay = s2_avg[LANE_Y];
      end
      default: begin
        fx = $signed(cfg.x_factor); ax = s2_avg[LANE_Y];
        fy = $signed(cfg.y_factor); ay = s2_avg[LANE_X];
      end
    endcase
    p_x_next = fx * $signed({1'b0, ax});
    p_y_next = fy * $signed({1'b0, ay});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= job_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_zero  <= job.zero;
      s1_pen   <= job.pen;
      s1_sum   <= job.sum;
      s1_qe    <= qe_next;
      s2_zero  <= s1_zero;
      s2_pen   <= s1_pen;
      s2_avg   <= avg_next;
      s3_zero  <= s2_zero;
      s3_pen   <= s2_pen;
      s3_avg_z <= s2_avg[LANE_Z];
      s3_p_x   <= p_x_next;
      s3_p_y   <= p_y_next;
    end
  end

  // integer parts; the fractional product is floored then added
  assign w_ext  = $signed({4'd0, cfg.screen_width});
  assign h_ext  = $signed({4'd0, cfg.screen_height});
  assign xo_ext = $signed({{4{cfg.x_offset[15]}}, cfg.x_offset});
  assign yo_ext = $signed({{4{cfg.y_offset[15]}}, cfg.y_offset});

  always_comb begin
    unique case (orient)
      ORIENT_PORTRAIT: begin
        neg_x = 1'b0; base_x = yo_ext;
        neg_y = 1'b0; base_y = xo_ext;
      end
      ORIENT_PORTRAIT_FLIP: begin
        neg_x = 1'b1; base_x = w_ext + yo_ext;
        neg_y = 1'b1; base_y = h_ext - xo_ext;
      end
      ORIENT_LANDSCAPE: begin
        neg_x = 1'b0; base_x = xo_ext;
        neg_y = 1'b1; base_y = h_ext + yo_ext;
      end
      default: begin
        neg_x = 1'b0; base_x = yo_ext;
        neg_y = 1'b1; base_y = h_ext + xo_ext;
      end
    endcase
  end

  always_comb begin
    pn_x = neg_x ? -s3_p_x : s3_p_x;
    pn_y = neg_y ? -s3_p_y : s3_p_y;
    c_x  = $signed({{(ACC_W-FLR_W){pn_x[PROD_W-1]}}, pn_x[PROD_W-1:20]}) + base_x;
    c_y  = $signed({{(ACC_W-FLR_W){pn_y[PROD_W-1]}}, pn_y[PROD_W-1:20]}) + base_y;
    if (c_x[ACC_W-1]) begin
      sat_x = '0;
    end else if (c_x[ACC_W-2:16] != '0) begin
      sat_x = 16'hFFFF;
    end else begin
      sat_x = c_x[15:0];
    end
    if (c_y[ACC_W-1]) begin
      sat_y = '0;
    end else if (c_y[ACC_W-2:16] != '0) begin
      sat_y = 16'hFFFF;
    end else begin
      sat_y = c_y[15:0];
    end
    press = cfg.control_mode[CM_PEN_IRQ] ? s3_pen : (s3_avg_z > cfg.z_threshold);
    if (s3_zero) begin
      res = '0;
    end else begin
      res.pos_x    = press ? sat_x : '0;
      res.pos_y    = press ? sat_y : '0;
      res.pressure = s3_avg_z;
      res.pressed  = press;
    end
  end

  `TSAC_ASSERT_NEXT(a_s2_to_s3, clk, rst, s2_valid && adv, s3_valid)
  `TSAC_ASSERT_IMP(a_div_remainder, clk, rst, s1_valid, (rem[LANE_X] < SUM_W'(2 * ROUNDS_PER_BATCH)) && (rem[LANE_Y] < SUM_W'(2 * ROUNDS_PER_BATCH)) && (rem[LANE_Z] < SUM_W'(2 * ROUNDS_PER_BATCH)))
  `TSAC_ASSERT_NEXT(a_hold_on_stall, clk, rst, s3_valid && res_full, s3_valid && $stable(s3_p_x) && $stable(s3_p_y))
  `TSAC_ASSERT_IMP(a_pen_up_zero, clk, rst, s3_valid && s3_zero, res == '0)

endmodule

`default_nettype wire

### design/touch_sample_average_calibrate_core.sv
// Resistive touch averaging and calibration core. One converter round (X, Y,
// Z1 bytes and the pen level) is taken per clock while full is low; the front
// end accumulates ROUNDS_PER_BATCH rounds and queues the batch sums, so the
// sustained input rate is one round per cycle, set by the accumulator. The back
// end divides by reciprocal multiply, applies one Q4.20 multiply per axis and
// saturates; the result passes through the job queue, the three back-end
// stages and the output queue before it shows on the output. A pen-up round at
// the start of a batch in interrupt mode gives an all-zero result for that
// round alone along the same path. Both sides stall independently through
// two-entry queues.
// Registers: control_mode, screen_width, screen_height, x_factor, y_factor,
// x_offset, y_offset, z_threshold at indexes 0..7; write only while idle.
`default_nettype none

module touch_sample_average_calibrate_core
  import tsac_pkg::*;
#(
  parameter int ROUNDS_PER_BATCH = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire in_t                    in_data,
  output logic                        empty,
  input  wire logic                   pop,
  output out_t                        out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  logic job_push;
  job_t job;
  logic job_full;
  logic job_empty;
  logic job_pop;
  logic [$bits(job_t)-1:0] job_raw;
  logic res_push;
  out_t res;
  logic res_full;
  logic [$bits(out_t)-1:0] out_raw;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CONTROL_MODE:  cfg.control_mode  <= cfg_data[3:0];
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[15:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[15:0];
        REG_X_FACTOR:      cfg.x_factor      <= cfg_data[23:0];
        REG_Y_FACTOR:      cfg.y_factor      <= cfg_data[23:0];
        REG_X_OFFSET:      cfg.x_offset      <= cfg_data[15:0];
        REG_Y_OFFSET:      cfg.y_offset      <= cfg_data[15:0];
        REG_Z_THRESHOLD:   cfg.z_threshold   <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  tsac_front #(
    .ROUNDS_PER_BATCH(ROUNDS_PER_BATCH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .job_push (job_push),
    .job      (job),
    .job_full (job_full)
  );

  tsac_queue #(
    .WIDTH($bits(job_t)),
    .DEPTH(2)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_raw),
    .empty   (job_empty)
  );

  tsac_back #(
    .ROUNDS_PER_BATCH(ROUNDS_PER_BATCH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (!job_empty),
    .job       (job_t'(job_raw)),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  tsac_queue #(
    .WIDTH($bits(out_t)),
    .DEPTH(2)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_raw),
    .empty   (empty)
  );

  assign out_data = out_t'(out_raw);

endmodule

`default_nettype wire
